// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the scaler address generator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define NNSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition in one cycle implies a consequence in the next.
`define NNSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/nnsa_pkg.sv =====
// ---------------------------------------------------------------------------
// nnsa_pkg
// Types, codes and helpers shared by the scaler address generator.
// ---------------------------------------------------------------------------
package nnsa_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = 12;
  localparam int PROD_W  = 24;

  // register indexes
  localparam logic [2:0] REG_HOST_W = 3'd0;
  localparam logic [2:0] REG_HOST_H = 3'd1;
  localparam logic [2:0] REG_EMU_W  = 3'd2;
  localparam logic [2:0] REG_EMU_H  = 3'd3;
  localparam logic [2:0] REG_ASP_W  = 3'd4;
  localparam logic [2:0] REG_ASP_H  = 3'd5;
  localparam logic [2:0] REG_MODE   = 3'd6;
  localparam logic [2:0] REG_PITCH  = 3'd7;

  // stretch modes
  localparam logic [1:0] MODE_INT  = 2'd0;
  localparam logic [1:0] MODE_EMU  = 2'd1;
  localparam logic [1:0] MODE_ASP  = 2'd2;
  localparam logic [1:0] MODE_FILL = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_SCALE0,
    OP_MUL_FW,
    OP_CHK_FW,
    OP_MUL_FH,
    OP_HOST,
    OP_FIN,
    OP_CLR,
    OP_WRAP,
    OP_MUL_X,
    OP_MUL_Y,
    OP_ADDR,
    OP_PUT,
    OP_DIV_GO,
    OP_DIV_DONE
  } op_t;

  typedef enum logic [2:0] {
    TGT_KX,
    TGT_KY,
    TGT_FW,
    TGT_FH,
    TGT_X,
    TGT_Y
  } tgt_t;

  typedef struct packed {
    op_t  op;
    tgt_t tgt;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       w_gt_host;
    logic       drawn_zero;
    logic       div_done;
    logic       out_free;
  } sts_t;

  // zero divisor acts as one
  function automatic logic [DIM_W-1:0] nz(input logic [DIM_W-1:0] v);
    return (v == '0) ? DIM_W'(1) : v;
  endfunction

  // clamp a drawn dimension to the host size and the dimension limit
  function automatic logic [DIM_W-1:0] sat_dim(input logic [PROD_W-1:0] v,
                                               input logic [DIM_W-1:0]  host);
    logic [PROD_W-1:0] t;
    t = v;
    if (t > {{(PROD_W-DIM_W){1'b0}}, host}) t = {{(PROD_W-DIM_W){1'b0}}, host};
    if (t > PROD_W'(MAX_DIM - 1)) t = PROD_W'(MAX_DIM - 1);
    return t[DIM_W-1:0];
  endfunction

endpackage

// ===== design/nnsa_div.sv =====
// ---------------------------------------------------------------------------
// nnsa_div
// Restoring divider, 24-bit dividend by 12-bit divisor, one bit per cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nnsa_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] dvd,
  input  logic [11:0] dvs,
  output logic [23:0] quo,
  output logic        done
);
  import nnsa_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [11:0] rem_r, rem_nxt;
  logic [23:0] q_r, q_nxt;
  logic [11:0] dvs_r, dvs_nxt;
  logic [12:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, q_r[23]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd23;
      rem_nxt  = '0;
      q_nxt    = dvd;
      dvs_nxt  = dvs;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 12'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[22:0], 1'b1};
      end else begin
        rem_nxt = trial[11:0];
        q_nxt   = {q_r[22:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quo  = q_r;
  assign done = done_r;

  `NNSA_ASSERT(a_dvs_nz, busy_r |-> (dvs_r != '0))
  `NNSA_ASSERT_NEXT(a_done_after_busy, done_r, !busy_r)

endmodule

// ===== design/nnsa_dp.sv =====
// ---------------------------------------------------------------------------
// nnsa_dp
// Datapath: config registers, frame geometry, counters, shared multiplier
// and divider, output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nnsa_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  nnsa_pkg::cmd_t     cmd,
  output nnsa_pkg::sts_t     sts,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [79:0]        out_tdata,
  output logic               out_tuser,
  output logic               out_tlast
);
  import nnsa_pkg::*;

  // config
  logic [11:0] hw_r, hh_r, ew_r, eh_r, aw_r, ah_r;
  logic [1:0]  mode_r;
  logic [12:0] pitch_r;

  // geometry and walk
  logic [11:0] kx_r, kx_nxt, ky_r, ky_nxt;
  logic [23:0] w_r, w_nxt, h_r, h_nxt;
  logic [11:0] dw_r, dw_nxt, dh_r, dh_nxt, ox_r, ox_nxt, oy_r, oy_nxt;
  logic [11:0] col_r, col_nxt, row_r, row_nxt;
  logic [11:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [23:0] prod_r, prod_nxt, psrc_r, psrc_nxt;
  logic [24:0] pdst_r, pdst_nxt;

  // output
  logic        ov_r, ov_nxt;
  logic [11:0] osx_r, osx_nxt, osy_r, osy_nxt;
  logic [23:0] osrc_r, osrc_nxt;
  logic [24:0] odst_r, odst_nxt;
  logic        ole_r, ole_nxt, ofe_r, ofe_nxt;

  logic [11:0] rw, rh, mul_a, mul_b, k, sdw, sdh;
  logic [23:0] dvd, quo;
  logic [11:0] dvs;
  logic        div_done, le, fe, out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r    <= 12'd640;
      hh_r    <= 12'd480;
      ew_r    <= 12'd640;
      eh_r    <= 12'd400;
      aw_r    <= 12'd4;
      ah_r    <= 12'd3;
      mode_r  <= MODE_INT;
      pitch_r <= 13'd640;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HOST_W: hw_r    <= cfg_data[11:0];
        REG_HOST_H: hh_r    <= cfg_data[11:0];
        REG_EMU_W:  ew_r    <= cfg_data[11:0];
        REG_EMU_H:  eh_r    <= cfg_data[11:0];
        REG_ASP_W:  aw_r    <= cfg_data[11:0];
        REG_ASP_H:  ah_r    <= cfg_data[11:0];
        REG_MODE:   mode_r  <= cfg_data[1:0];
        REG_PITCH:  pitch_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rw = (mode_r == MODE_EMU) ? nz(ew_r) : nz(aw_r);
  assign rh = (mode_r == MODE_EMU) ? nz(eh_r) : nz(ah_r);
  assign k  = (kx_r < ky_r) ? ((kx_r <= 12'd1) ? 12'd1 : kx_r)
                            : ((ky_r <= 12'd1) ? 12'd1 : ky_r);
  assign sdw = sat_dim(w_r, hw_r);
  assign sdh = sat_dim(h_r, hh_r);
  assign le  = (col_r == dw_r - 12'd1);
  assign fe  = le && (row_r == dh_r - 12'd1);
  assign out_free = !ov_r || out_tready;

  // shared multiplier operands
  always_comb begin
    case (cmd.op)
      OP_MUL_FW: begin mul_a = hh_r;  mul_b = rw;   end
      OP_MUL_FH: begin mul_a = hw_r;  mul_b = rh;   end
      OP_MUL_X:  begin mul_a = col_r; mul_b = ew_r; end
      default:   begin mul_a = row_r; mul_b = eh_r; end
    endcase
  end

  // divider operands
  always_comb begin
    case (cmd.tgt)
      TGT_KX: begin dvd = {12'd0, hw_r}; dvs = nz(ew_r); end
      TGT_KY: begin dvd = {12'd0, hh_r}; dvs = nz(eh_r); end
      TGT_FW: begin dvd = prod_r;        dvs = rh;       end
      TGT_FH: begin dvd = prod_r;        dvs = rw;       end
      TGT_X:  begin dvd = prod_r;        dvs = dw_r;     end
      default: begin dvd = prod_r;       dvs = dh_r;     end
    endcase
  end

  nnsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_DIV_GO),
    .dvd   (dvd),
    .dvs   (dvs),
    .quo   (quo),
    .done  (div_done)
  );

  always_comb begin
    kx_nxt = kx_r;   ky_nxt = ky_r;   w_nxt = w_r;     h_nxt = h_r;
    dw_nxt = dw_r;   dh_nxt = dh_r;   ox_nxt = ox_r;   oy_nxt = oy_r;
    col_nxt = col_r; row_nxt = row_r; sx_nxt = sx_r;   sy_nxt = sy_r;
    prod_nxt = prod_r; psrc_nxt = psrc_r; pdst_nxt = pdst_r;
    ov_nxt = ov_r && !out_tready;
    osx_nxt = osx_r; osy_nxt = osy_r; osrc_nxt = osrc_r; odst_nxt = odst_r;
    ole_nxt = ole_r; ofe_nxt = ofe_r;
    case (cmd.op)
      OP_SCALE0: begin
        w_nxt = {12'd0, ew_r} * {12'd0, k};
        h_nxt = {12'd0, eh_r} * {12'd0, k};
      end
      OP_MUL_FW, OP_MUL_FH, OP_MUL_X, OP_MUL_Y:
        prod_nxt = {12'd0, mul_a} * {12'd0, mul_b};
      OP_CHK_FW: begin
        if (sts.w_gt_host) w_nxt = {12'd0, hw_r};
        else               h_nxt = {12'd0, hh_r};
      end
      OP_HOST: begin
        w_nxt = {12'd0, hw_r};
        h_nxt = {12'd0, hh_r};
      end
      OP_FIN: begin
        dw_nxt  = sdw;
        dh_nxt  = sdh;
        ox_nxt  = (hw_r - sdw) >> 1;
        oy_nxt  = (hh_r - sdh) >> 1;
        col_nxt = '0;
        row_nxt = '0;
      end
      OP_CLR: begin
        col_nxt = '0;
        row_nxt = '0;
      end
      OP_WRAP: begin
        if (col_r >= dw_r) col_nxt = '0;
        if (row_r >= dh_r) row_nxt = '0;
      end
      OP_ADDR: begin
        psrc_nxt = {12'd0, sy_r} * {12'd0, ew_r};
        pdst_nxt = 25'(({1'b0, oy_r} + {1'b0, row_r}) * pitch_r);
      end
      OP_PUT: begin
        ov_nxt   = 1'b1;
        osx_nxt  = sx_r;
        osy_nxt  = sy_r;
        osrc_nxt = psrc_r + {12'd0, sx_r};
        odst_nxt = pdst_r + {13'd0, ox_r} + {13'd0, col_r};
        ole_nxt  = le;
        ofe_nxt  = fe;
        if (le) begin
          col_nxt = '0;
          row_nxt = fe ? '0 : row_r + 12'd1;
        end else begin
          col_nxt = col_r + 12'd1;
        end
      end
      OP_DIV_DONE: begin
        case (cmd.tgt)
          TGT_KX:  kx_nxt = quo[11:0];
          TGT_KY:  ky_nxt = quo[11:0];
          TGT_FW:  w_nxt  = quo;
          TGT_FH:  h_nxt  = quo;
          TGT_X:   sx_nxt = quo[11:0];
          default: sy_nxt = quo[11:0];
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dw_r  <= '0;
      dh_r  <= '0;
      ox_r  <= '0;
      oy_r  <= '0;
      col_r <= '0;
      row_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      dw_r  <= dw_nxt;
      dh_r  <= dh_nxt;
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      ov_r  <= ov_nxt;
    end
    kx_r   <= kx_nxt;
    ky_r   <= ky_nxt;
    w_r    <= w_nxt;
    h_r    <= h_nxt;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    prod_r <= prod_nxt;
    psrc_r <= psrc_nxt;
    pdst_r <= pdst_nxt;
    osx_r  <= osx_nxt;
    osy_r  <= osy_nxt;
    osrc_r <= osrc_nxt;
    odst_r <= odst_nxt;
    ole_r  <= ole_nxt;
    ofe_r  <= ofe_nxt;
  end

  assign sts.mode       = mode_r;
  assign sts.w_gt_host  = (w_r > {12'd0, hw_r});
  assign sts.drawn_zero = (dw_r == '0) || (dh_r == '0);
  assign sts.div_done   = div_done;
  assign sts.out_free   = out_free;

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, odst_r, osrc_r, osy_r, osx_r};
  assign out_tuser  = ole_r;
  assign out_tlast  = ofe_r;

  `NNSA_ASSERT(a_put_free, (cmd.op == OP_PUT) |-> out_free)
  `NNSA_ASSERT(a_walk_zero, sts.drawn_zero |-> (cmd.op != OP_PUT))

endmodule

// ===== design/nnsa_ctrl.sv =====
// ---------------------------------------------------------------------------
// nnsa_ctrl
// Sequencer: restart geometry, per-pixel divide steps, output hand-off.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nnsa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           in_restart,
  input  nnsa_pkg::sts_t sts,
  output nnsa_pkg::cmd_t cmd
);
  import nnsa_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_RC     = 14'b00000000000010,
    S_RC_KY  = 14'b00000000000100,
    S_SCALE0 = 14'b00000000001000,
    S_CHK    = 14'b00000000010000,
    S_MULH   = 14'b00000000100000,
    S_FIN    = 14'b00000001000000,
    S_PIX    = 14'b00000010000000,
    S_MULX   = 14'b00000100000000,
    S_MULY   = 14'b00001000000000,
    S_ADDR   = 14'b00010000000000,
    S_PUT    = 14'b00100000000000,
    S_DGO    = 14'b01000000000000,
    S_DWAIT  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  tgt_t   tgt_r, tgt_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    tgt_nxt   = tgt_r;
    cmd.op    = OP_NONE;
    cmd.tgt   = tgt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = in_restart ? S_RC : S_PIX;
      end
      S_RC: begin
        unique case (sts.mode) inside
          MODE_INT: begin
            tgt_nxt   = TGT_KX;
            ret_nxt   = S_RC_KY;
            state_nxt = S_DGO;
          end
          MODE_EMU, MODE_ASP: begin
            cmd.op    = OP_MUL_FW;
            tgt_nxt   = TGT_FW;
            ret_nxt   = S_CHK;
            state_nxt = S_DGO;
          end
          default: begin
            cmd.op    = OP_HOST;
            state_nxt = S_FIN;
          end
        endcase
      end
      S_RC_KY: begin
        tgt_nxt   = TGT_KY;
        ret_nxt   = S_SCALE0;
        state_nxt = S_DGO;
      end
      S_SCALE0: begin
        cmd.op    = OP_SCALE0;
        state_nxt = S_FIN;
      end
      S_CHK: begin
        cmd.op    = OP_CHK_FW;
        state_nxt = sts.w_gt_host ? S_MULH : S_FIN;
      end
      S_MULH: begin
        cmd.op    = OP_MUL_FH;
        tgt_nxt   = TGT_FH;
        ret_nxt   = S_FIN;
        state_nxt = S_DGO;
      end
      S_FIN: begin
        cmd.op    = OP_FIN;
        state_nxt = S_PIX;
      end
      S_PIX: begin
        if (sts.drawn_zero) begin
          cmd.op    = OP_CLR;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_WRAP;
          state_nxt = S_MULX;
        end
      end
      S_MULX: begin
        cmd.op    = OP_MUL_X;
        tgt_nxt   = TGT_X;
        ret_nxt   = S_MULY;
        state_nxt = S_DGO;
      end
      S_MULY: begin
        cmd.op    = OP_MUL_Y;
        tgt_nxt   = TGT_Y;
        ret_nxt   = S_ADDR;
        state_nxt = S_DGO;
      end
      S_ADDR: begin
        cmd.op    = OP_ADDR;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.op    = OP_PUT;
          state_nxt = S_IDLE;
        end
      end
      S_DGO: begin
        cmd.op    = OP_DIV_GO;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.op    = OP_DIV_DONE;
          state_nxt = ret_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      tgt_r   <= TGT_KX;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      tgt_r   <= tgt_nxt;
    end
  end

  `NNSA_ASSERT(a_done_in_wait, sts.div_done |-> (state_r == S_DWAIT))
  `NNSA_ASSERT_NEXT(a_go_wait, state_r == S_DGO, state_r == S_DWAIT)

endmodule

// ===== design/nearest_neighbor_scaler_addresses.sv =====
// Sequence: a plain step runs the wrap, x multiply, x divide, y multiply, y divide,
// address and put states before the result lands in the output register; a restart
// step first runs its geometry steps. Throughput: one request at a time, taken
// only once the last result is put; the bit-serial divider is used twice per pixel.
// Reset: rst_n synchronous, active low; registers take their documented
// defaults, drawn size and counters clear, so steps give no result until restart.
// ---------------------------------------------------------------------------
// nearest_neighbor_scaler_addresses
// Nearest-neighbor scaler address generator: sequencer plus datapath.
// ---------------------------------------------------------------------------
module nearest_neighbor_scaler_addresses (
  input  logic        clk,
  input  logic        rst_n,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] restart, [7:1] zero
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [11:0] src_x, [23:12] src_y,
                                  // [47:24] src_addr, [72:48] dst_addr, [79:73] zero
  output logic        out_tuser,  // [0] line_end
  output logic        out_tlast   // frame_end
);
  import nnsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: walks restart geometry and the per-pixel divide/multiply steps
  nnsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_restart (in_tdata[0]),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath: registers, geometry, counters, shared mul/div, output stage
  nnsa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sim/nearest_neighbor_scaler_addresses_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// nearest_neighbor_scaler_addresses_tb
// Self-checking bench for the scaler address generator. Configures the
// stretch registers, sends restart and step requests under several idling
// phases and compares every pixel address against an in-bench predictor.
// ---------------------------------------------------------------------------
module nearest_neighbor_scaler_addresses_tb;
  import nnsa_pkg::*;

  typedef struct packed {
    logic        frame_end;
    logic        line_end;
    logic [24:0] dst_addr;
    logic [23:0] src_addr;
    logic [11:0] src_y;
    logic [11:0] src_x;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  nearest_neighbor_scaler_addresses u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #10 clk = ~clk;

  // predictor state: registers plus the frame walk
  logic [11:0] m_host_w, m_host_h, m_emu_w, m_emu_h, m_asp_w, m_asp_h;
  logic [1:0]  m_mode;
  logic [12:0] m_pitch;
  logic [11:0] m_col, m_row, m_drawn_w, m_drawn_h, m_off_x, m_off_y;

  pixel_t pending_pixels[$];
  int     n_mismatch = 0;
  int     n_checked = 0;
  int     n_sent = 0;
  int     send_idle_pct = 0;   // sender gap chance, percent
  int     recv_stall_pct = 0;  // receiver stall chance, percent
  int     hold_off_reqs = 0;   // long hold-offs asked for by the tests
  int     hold_off_seen = 0;   // long hold-offs started by the receiver
  int     hold_off_cycles = 0; // long receiver hold-off, counted below

  function automatic longint unsigned nzv(longint unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic longint unsigned clamp_dim(longint unsigned v, longint unsigned host);
    if (v > host) v = host;
    if (v > MAX_DIM - 1) v = MAX_DIM - 1;
    return v;
  endfunction

  // fix drawn size and centering from the stretch mode
  task automatic compute_drawn_size();
    longint unsigned w, h, k, kx, ky, rw, rh;
    if (m_mode == MODE_INT) begin
      kx = m_host_w / nzv(m_emu_w);
      ky = m_host_h / nzv(m_emu_h);
      k = (kx < ky) ? kx : ky;
      if (k <= 1) k = 1;
      w = m_emu_w * k;
      h = m_emu_h * k;
    end else if (m_mode == MODE_FILL) begin
      w = m_host_w;
      h = m_host_h;
    end else begin
      rw = nzv((m_mode == MODE_EMU) ? m_emu_w : m_asp_w);
      rh = nzv((m_mode == MODE_EMU) ? m_emu_h : m_asp_h);
      w = (m_host_h * rw) / rh;
      h = m_host_h;
      if (w > m_host_w) begin
        w = m_host_w;
        h = (m_host_w * rh) / rw;
      end
    end
    m_drawn_w = clamp_dim(w, m_host_w);
    m_drawn_h = clamp_dim(h, m_host_h);
    m_off_x = (m_host_w - m_drawn_w) / 2;
    m_off_y = (m_host_h - m_drawn_h) / 2;
    m_col = 0;
    m_row = 0;
  endtask

  // advance the walk by one request, queueing the pixel it yields
  task automatic predict_pixel(input logic restart);
    longint unsigned sx, sy;
    pixel_t p;
    if (restart) compute_drawn_size();
    if (m_drawn_w == 0 || m_drawn_h == 0) begin
      m_col = 0;
      m_row = 0;
    end else begin
      if (m_col >= m_drawn_w) m_col = 0;
      if (m_row >= m_drawn_h) m_row = 0;
      sx = (64'(m_col) * m_emu_w) / m_drawn_w;
      sy = (64'(m_row) * m_emu_h) / m_drawn_h;
      p.src_x = sx[11:0];
      p.src_y = sy[11:0];
      p.src_addr = 24'(sy * m_emu_w + sx);
      p.dst_addr = 25'((64'(m_off_y) + m_row) * m_pitch + m_off_x + m_col);
      p.line_end = (m_col == m_drawn_w - 1);
      p.frame_end = p.line_end && (m_row == m_drawn_h - 1);
      pending_pixels.push_back(p);
      if (p.line_end) begin
        m_col = 0;
        m_row = p.frame_end ? 12'd0 : m_row + 12'd1;
      end else begin
        m_col = m_col + 12'd1;
      end
    end
  endtask

  // valid stays high across back-to-back writes; the caller drops it
  task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HOST_W: m_host_w = val[11:0];
      REG_HOST_H: m_host_h = val[11:0];
      REG_EMU_W:  m_emu_w = val[11:0];
      REG_EMU_H:  m_emu_h = val[11:0];
      REG_ASP_W:  m_asp_w = val[11:0];
      REG_ASP_H:  m_asp_h = val[11:0];
      REG_MODE:   m_mode = val[1:0];
      default:    m_pitch = val;
    endcase
  endtask

  // one request; valid stays high across back-to-back requests
  task automatic send_request(input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, restart};
    do @(posedge clk); while (!in_tready);
    predict_pixel(restart);
    n_sent++;
  endtask

  // wait for all pixels, then the block latency so an empty step finishes
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic program_frame(input int hw, hh, ew, eh, aw, ah, md, pt);
    write_reg(REG_HOST_W, 13'(hw));
    write_reg(REG_HOST_H, 13'(hh));
    write_reg(REG_EMU_W, 13'(ew));
    write_reg(REG_EMU_H, 13'(eh));
    write_reg(REG_ASP_W, 13'(aw));
    write_reg(REG_ASP_H, 13'(ah));
    write_reg(REG_MODE, 13'(md));
    write_reg(REG_PITCH, 13'(pt));
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_off_reqs != hold_off_seen) begin
      hold_off_seen <= hold_off_reqs;
      hold_off_cycles <= 600;
      out_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    pixel_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tlast, out_tuser, out_tdata[72:0]};
      if (pending_pixels.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected pixel %h", got);
      end else begin
        want = pending_pixels.pop_front();
        n_checked++;
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"pixel mismatch: exp x=%0d y=%0d sa=%0d da=%0d le=%b fe=%b",
                      " got x=%0d y=%0d sa=%0d da=%0d le=%b fe=%b"},
                     want.src_x, want.src_y, want.src_addr, want.dst_addr,
                     want.line_end, want.frame_end, got.src_x, got.src_y,
                     got.src_addr, got.dst_addr, got.line_end, got.frame_end);
        end
      end
    end
  end

  // steps before any restart give nothing; then tiny frames with wrap
  task automatic test_directed();
    send_request(1'b0);
    send_request(1'b0);
    drain();
    // integer multiple, tiny emulated screen inside a small host
    program_frame(7, 5, 3, 2, 4, 3, MODE_INT, 13);
    send_request(1'b1);
    repeat (7) send_request(1'b0);
    drain();
    // zero emu and aspect registers act as one; extremes of pitch
    program_frame(4095, 4095, 0, 0, 0, 0, MODE_ASP, 8191);
    send_request(1'b1);
    send_request(1'b0);
    drain();
    program_frame(1, 1, 4095, 4095, 4095, 1, MODE_EMU, 1);
    send_request(1'b1);
    send_request(1'b0);
    drain();
    program_frame(3, 2, 4095, 1, 1, 4095, MODE_FILL, 1);
    send_request(1'b1);
    repeat (6) send_request(1'b0);
    drain();
    // register change mid-frame: pitch and emu read live
    write_reg(REG_PITCH, 13'd100);
    write_reg(REG_EMU_W, 13'd9);
    cfg_valid <= 1'b0;
    send_request(1'b0);
    send_request(1'b1);
    drain();
  endtask

  // random small geometries with mostly plain steps and some restarts
  task automatic test_random(input int n_req, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n_req; i++) begin
      if (i % 45 == 0) begin
        drain();
        program_frame($urandom_range(1, 24), $urandom_range(1, 16),
                      $urandom_range(0, 30), $urandom_range(0, 20),
                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 3), $urandom_range(1, 8191));
        send_request(1'b1);
      end else begin
        send_request($urandom_range(99) < 8);
      end
    end
    drain();
  endtask

  // hold the receiver off while the sender keeps offering requests
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    program_frame(640, 480, 320, 200, 4, 3, MODE_INT, 640);
    hold_off_reqs++;
    send_request(1'b1);
    repeat (10) send_request(1'b0);
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    m_host_w = 640; m_host_h = 480; m_emu_w = 640; m_emu_h = 400;
    m_asp_w = 4; m_asp_h = 3; m_mode = MODE_INT; m_pitch = 640;
    m_col = 0; m_row = 0; m_drawn_w = 0; m_drawn_h = 0; m_off_x = 0; m_off_y = 0;
    test_directed();
    test_random(140, 0, 0);
    test_random(140, 70, 0);
    test_random(140, 0, 70);
    test_random(130, 23, 23);
    test_backpressure();
    $display("covered %0d requests and %0d checked pixels across all stretch modes,",
             n_sent, n_checked);
    $display("under sender gaps, receiver stalls and a long output hold-off");
    if (n_mismatch == 0 && pending_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/nnsa_pkg.sv
design/nnsa_div.sv
design/nnsa_dp.sv
design/nnsa_ctrl.sv
design/nearest_neighbor_scaler_addresses.sv
sim/nearest_neighbor_scaler_addresses_tb.sv
